@@ rtl/core/rfa_pkg.sv @@
// ----------------------------------------------------------------------------
// rfa_pkg
// Shared types and constants of the rational fraction ALU.
// ----------------------------------------------------------------------------
package rfa_pkg;

    localparam int RFA_QUEUE_DEPTH = 2;
    localparam int RFA_IN_W        = 32;
    localparam int RFA_WORK_W      = 64;

    typedef enum logic [2:0] {
        OP_ADD = 3'd0,
        OP_SUB = 3'd1,
        OP_MUL = 3'd2,
        OP_DIV = 3'd3,
        OP_EQ  = 3'd4,
        OP_GT  = 3'd5,
        OP_LT  = 3'd6,
        OP_NOP = 3'd7
    } t_opc;

    typedef struct packed {
        t_opc                       op;
        logic signed [RFA_IN_W-1:0] na;
        logic signed [RFA_IN_W-1:0] da;
        logic signed [RFA_IN_W-1:0] nb;
        logic signed [RFA_IN_W-1:0] db;
    } t_job;

    typedef struct packed {
        logic push;
        logic full;
    } t_front_ctl;

    typedef enum logic [1:0] {
        RED_IDLE,
        RED_GCD,
        RED_DIV
    } t_red_state;

    typedef enum logic [3:0] {
        BK_IDLE,
        BK_NA_GO,
        BK_NA_WAIT,
        BK_NB_GO,
        BK_NB_WAIT,
        BK_MUL,
        BK_EVAL,
        BK_RED_GO,
        BK_RED_WAIT,
        BK_OUT
    } t_bk_state;

endpackage

@@ rtl/core/rfa_front.sv @@
// ----------------------------------------------------------------------------
// rfa_front
// Input side: accepts transactions, decodes the opcode, maps zero
// denominators to one and pushes the job into the queue.
// ----------------------------------------------------------------------------
module rfa_front (
    input  logic                         i_valid,
    output logic                         o_ready,
    input  logic [2:0]                   i_opcode,
    input  logic signed [31:0]           i_num_a,
    input  logic signed [31:0]           i_den_a,
    input  logic signed [31:0]           i_num_b,
    input  logic signed [31:0]           i_den_b,
    input  logic                         i_full,
    output rfa_pkg::t_front_ctl          o_ctl,
    output rfa_pkg::t_job                o_job
);
    import rfa_pkg::*;

    t_opc op;

    always_comb begin
        op = t_opc'(i_opcode);
    end

    always_comb begin
        o_job.op = op;
        o_job.na = i_num_a;
        o_job.da = (i_den_a == '0) ? 32'sd1 : i_den_a;
        o_job.nb = i_num_b;
        o_job.db = (i_den_b == '0) ? 32'sd1 : i_den_b;
    end

    assign o_ready    = !i_full;
    assign o_ctl.full = i_full;
    assign o_ctl.push = i_valid && !i_full;

endmodule

@@ rtl/core/rfa_queue.sv @@
// ----------------------------------------------------------------------------
// rfa_queue
// Short job queue between the front and back parts.
// ----------------------------------------------------------------------------
module rfa_queue #(
    parameter int DEPTH = rfa_pkg::RFA_QUEUE_DEPTH
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_push,
    input  rfa_pkg::t_job i_job,
    output logic          o_full,
    input  logic          i_pop,
    output logic          o_valid,
    output rfa_pkg::t_job o_job
);
    import rfa_pkg::*;

    localparam int PW = $clog2(DEPTH);
    localparam int CW = $clog2(DEPTH + 1);

    t_job            r_mem [DEPTH];
    logic [PW-1:0]   r_wp, n_wp;
    logic [PW-1:0]   r_rp, n_rp;
    logic [CW-1:0]   r_cnt, n_cnt;

    always_comb begin
        n_wp  = r_wp;
        n_rp  = r_rp;
        n_cnt = r_cnt;
        if (i_push) begin
            n_wp = (r_wp == PW'(DEPTH - 1)) ? '0 : r_wp + 1'b1;
        end
        if (i_pop) begin
            n_rp = (r_rp == PW'(DEPTH - 1)) ? '0 : r_rp + 1'b1;
        end
        if (i_push && !i_pop) begin
            n_cnt = r_cnt + 1'b1;
        end else if (i_pop && !i_push) begin
            n_cnt = r_cnt - 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= '0;
            r_rp  <= '0;
            r_cnt <= '0;
        end else begin
            r_wp  <= n_wp;
            r_rp  <= n_rp;
            r_cnt <= n_cnt;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wp] <= i_job;
        end
    end

    assign o_full  = (r_cnt == CW'(DEPTH));
    assign o_valid = (r_cnt != '0);
    assign o_job   = r_mem[r_rp];

endmodule

@@ rtl/core/rfa_reduce.sv @@
// ----------------------------------------------------------------------------
// rfa_reduce
// Binary GCD of two magnitudes, one step a cycle, then exact division of
// both by the GCD with two restoring dividers, one bit a cycle.
// ----------------------------------------------------------------------------
module rfa_reduce (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_start,
    input  logic [63:0] i_a,
    input  logic [63:0] i_b,
    output logic        o_done,
    output logic [63:0] o_qa,
    output logic [63:0] o_qb
);
    import rfa_pkg::*;

    t_red_state  r_state, n_state;
    logic [63:0] r_x, n_x;
    logic [63:0] r_y, n_y;
    logic [5:0]  r_k, n_k;
    logic [63:0] r_g, n_g;
    logic [5:0]  r_cnt, n_cnt;
    logic [63:0] r_qa, n_qa;
    logic [63:0] r_qb, n_qb;
    logic [64:0] r_ra, n_ra;
    logic [64:0] r_rb, n_rb;
    logic        r_done, n_done;
    logic [64:0] ra_sh, rb_sh;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= RED_IDLE;
            r_done  <= 1'b0;
        end else begin
            r_state <= n_state;
            r_done  <= n_done;
        end
    end

    always_ff @(posedge i_clk) begin
        r_x   <= n_x;
        r_y   <= n_y;
        r_k   <= n_k;
        r_g   <= n_g;
        r_cnt <= n_cnt;
        r_qa  <= n_qa;
        r_qb  <= n_qb;
        r_ra  <= n_ra;
        r_rb  <= n_rb;
    end

    assign ra_sh = {r_ra[63:0], r_qa[63]};
    assign rb_sh = {r_rb[63:0], r_qb[63]};

    always_comb begin
        n_state = r_state;
        n_x     = r_x;
        n_y     = r_y;
        n_k     = r_k;
        n_g     = r_g;
        n_cnt   = r_cnt;
        n_qa    = r_qa;
        n_qb    = r_qb;
        n_ra    = r_ra;
        n_rb    = r_rb;
        n_done  = 1'b0;
        unique case (r_state)
            RED_IDLE: begin
                if (i_start) begin
                    n_x     = i_a;
                    n_y     = i_b;
                    n_k     = '0;
                    n_qa    = i_a;
                    n_qb    = i_b;
                    n_state = RED_GCD;
                end
            end
            RED_GCD: begin
                n_ra  = '0;
                n_rb  = '0;
                n_cnt = '0;
                if (r_x == '0) begin
                    n_g     = r_y << r_k;
                    n_state = RED_DIV;
                end else if (r_y == '0) begin
                    n_g     = r_x << r_k;
                    n_state = RED_DIV;
                end else if (!r_x[0] && !r_y[0]) begin
                    n_x = r_x >> 1;
                    n_y = r_y >> 1;
                    n_k = r_k + 1'b1;
                end else if (!r_x[0]) begin
                    n_x = r_x >> 1;
                end else if (!r_y[0]) begin
                    n_y = r_y >> 1;
                end else if (r_x >= r_y) begin
                    n_x = r_x - r_y;
                end else begin
                    n_y = r_y - r_x;
                end
            end
            RED_DIV: begin
                if (ra_sh >= {1'b0, r_g}) begin
                    n_ra = ra_sh - {1'b0, r_g};
                    n_qa = {r_qa[62:0], 1'b1};
                end else begin
                    n_ra = ra_sh;
                    n_qa = {r_qa[62:0], 1'b0};
                end
                if (rb_sh >= {1'b0, r_g}) begin
                    n_rb = rb_sh - {1'b0, r_g};
                    n_qb = {r_qb[62:0], 1'b1};
                end else begin
                    n_rb = rb_sh;
                    n_qb = {r_qb[62:0], 1'b0};
                end
                n_cnt = r_cnt + 1'b1;
                if (r_cnt == 6'd63) begin
                    n_done  = 1'b1;
                    n_state = RED_IDLE;
                end
            end
            default: n_state = RED_IDLE;
        endcase
    end

    assign o_done = r_done;
    assign o_qa   = r_qa;
    assign o_qb   = r_qb;

endmodule

@@ rtl/core/rfa_back.sv @@
// ----------------------------------------------------------------------------
// rfa_back
// Execution side: normalizes both operands, forms the cross products on a
// shared multiplier, evaluates the opcode and reduces arithmetic results.
// ----------------------------------------------------------------------------
module rfa_back (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_q_valid,
    input  rfa_pkg::t_job       i_job,
    output logic                o_pop,
    output logic                o_valid,
    input  logic                i_ready,
    output logic signed [63:0]  o_num_out,
    output logic [62:0]         o_den_out,
    output logic                o_compare_true,
    output logic                o_div_zero_error
);
    import rfa_pkg::*;

    t_bk_state          r_state, n_state;
    t_opc               r_op, n_op;
    logic signed [63:0] r_na, n_na, r_da, n_da, r_nb, n_nb, r_db, n_db;
    logic signed [63:0] r_p, n_p, r_q, n_q, r_dd, n_dd, r_nn, n_nn, r_dn, n_dn;
    logic [2:0]         r_mcnt, n_mcnt;
    logic [63:0]        r_m, n_m, r_den, n_den;
    logic               r_neg, n_neg;
    logic signed [63:0] r_num_out, n_num_out;
    logic [62:0]        r_den_out, n_den_out;
    logic               r_cmp, n_cmp, r_err, n_err;

    logic               red_start;
    logic [63:0]        red_a, red_b, red_qa, red_qb;
    logic               red_done;
    logic signed [32:0] mul_a, mul_b;
    logic signed [65:0] mul_p;
    logic [63:0]        sum;
    logic               sum_neg;

    rfa_reduce u_reduce (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (red_start),
        .i_a     (red_a),
        .i_b     (red_b),
        .o_done  (red_done),
        .o_qa    (red_qa),
        .o_qb    (red_qb)
    );

    always_comb begin
        case (r_mcnt)
            3'd0:    begin mul_a = r_na[32:0]; mul_b = r_db[32:0]; end
            3'd1:    begin mul_a = r_nb[32:0]; mul_b = r_da[32:0]; end
            3'd2:    begin mul_a = r_da[32:0]; mul_b = r_db[32:0]; end
            3'd3:    begin mul_a = r_na[32:0]; mul_b = r_nb[32:0]; end
            default: begin mul_a = r_da[32:0]; mul_b = r_nb[32:0]; end
        endcase
    end

    assign mul_p   = mul_a * mul_b;
    assign sum     = (r_op == OP_ADD) ? 64'(r_p) + 64'(r_q) : 64'(r_p) - 64'(r_q);
    assign sum_neg = sum[63];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= BK_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_ff @(posedge i_clk) begin
        r_op      <= n_op;
        r_na      <= n_na;
        r_da      <= n_da;
        r_nb      <= n_nb;
        r_db      <= n_db;
        r_p       <= n_p;
        r_q       <= n_q;
        r_dd      <= n_dd;
        r_nn      <= n_nn;
        r_dn      <= n_dn;
        r_mcnt    <= n_mcnt;
        r_m       <= n_m;
        r_den     <= n_den;
        r_neg     <= n_neg;
        r_num_out <= n_num_out;
        r_den_out <= n_den_out;
        r_cmp     <= n_cmp;
        r_err     <= n_err;
    end

    always_comb begin
        n_state   = r_state;
        n_op      = r_op;
        n_na      = r_na;
        n_da      = r_da;
        n_nb      = r_nb;
        n_db      = r_db;
        n_p       = r_p;
        n_q       = r_q;
        n_dd      = r_dd;
        n_nn      = r_nn;
        n_dn      = r_dn;
        n_mcnt    = r_mcnt;
        n_m       = r_m;
        n_den     = r_den;
        n_neg     = r_neg;
        n_num_out = r_num_out;
        n_den_out = r_den_out;
        n_cmp     = r_cmp;
        n_err     = r_err;
        o_pop     = 1'b0;
        red_start = 1'b0;
        red_a     = r_m;
        red_b     = r_den;
        unique case (r_state)
            BK_IDLE: begin
                if (i_q_valid) begin
                    o_pop   = 1'b1;
                    n_op    = i_job.op;
                    n_na    = 64'(i_job.na);
                    n_da    = 64'(i_job.da);
                    n_nb    = 64'(i_job.nb);
                    n_db    = 64'(i_job.db);
                    n_state = BK_NA_GO;
                end
            end
            BK_NA_GO: begin
                red_start = 1'b1;
                red_a     = r_na[63] ? 64'(-r_na) : 64'(r_na);
                red_b     = r_da[63] ? 64'(-r_da) : 64'(r_da);
                n_state   = BK_NA_WAIT;
            end
            BK_NA_WAIT: begin
                if (red_done) begin
                    n_na    = (r_na[63] ^ r_da[63]) ? -$signed(red_qa) : $signed(red_qa);
                    n_da    = $signed(red_qb);
                    n_state = BK_NB_GO;
                end
            end
            BK_NB_GO: begin
                red_start = 1'b1;
                red_a     = r_nb[63] ? 64'(-r_nb) : 64'(r_nb);
                red_b     = r_db[63] ? 64'(-r_db) : 64'(r_db);
                n_state   = BK_NB_WAIT;
            end
            BK_NB_WAIT: begin
                if (red_done) begin
                    n_nb    = (r_nb[63] ^ r_db[63]) ? -$signed(red_qa) : $signed(red_qa);
                    n_db    = $signed(red_qb);
                    n_mcnt  = '0;
                    n_state = BK_MUL;
                end
            end
            BK_MUL: begin
                case (r_mcnt)
                    3'd0:    n_p  = mul_p[63:0];
                    3'd1:    n_q  = mul_p[63:0];
                    3'd2:    n_dd = mul_p[63:0];
                    3'd3:    n_nn = mul_p[63:0];
                    default: n_dn = mul_p[63:0];
                endcase
                n_mcnt = r_mcnt + 1'b1;
                if (r_mcnt == 3'd4) begin
                    n_state = BK_EVAL;
                end
            end
            BK_EVAL: begin
                n_num_out = '0;
                n_den_out = 63'd1;
                n_cmp     = 1'b0;
                n_err     = 1'b0;
                n_state   = BK_OUT;
                unique case (r_op) inside
                    OP_ADD, OP_SUB: begin
                        n_neg   = sum_neg;
                        n_m     = sum_neg ? 64'(-sum) : sum;
                        n_den   = 64'(r_dd);
                        n_state = BK_RED_GO;
                    end
                    OP_MUL: begin
                        n_neg   = r_nn[63];
                        n_m     = r_nn[63] ? 64'(-r_nn) : 64'(r_nn);
                        n_den   = 64'(r_dd);
                        n_state = BK_RED_GO;
                    end
                    OP_DIV: begin
                        if (r_nb == '0) begin
                            n_err = 1'b1;
                        end else begin
                            n_neg   = r_p[63] ^ r_dn[63];
                            n_m     = r_p[63] ? 64'(-r_p) : 64'(r_p);
                            n_den   = r_dn[63] ? 64'(-r_dn) : 64'(r_dn);
                            n_state = BK_RED_GO;
                        end
                    end
                    OP_EQ:   n_cmp = (r_p == r_q);
                    OP_GT:   n_cmp = (r_p > r_q);
                    OP_LT:   n_cmp = (r_p < r_q);
                    default: n_cmp = 1'b0;
                endcase
            end
            BK_RED_GO: begin
                red_start = 1'b1;
                n_state   = BK_RED_WAIT;
            end
            BK_RED_WAIT: begin
                if (red_done) begin
                    n_num_out = (r_neg && red_qa != '0) ? -$signed(red_qa) : $signed(red_qa);
                    n_den_out = red_qb[62:0];
                    n_state   = BK_OUT;
                end
            end
            BK_OUT: begin
                if (i_ready) begin
                    n_state = BK_IDLE;
                end
            end
            default: n_state = BK_IDLE;
        endcase
    end

    assign o_valid          = (r_state == BK_OUT);
    assign o_num_out        = r_num_out;
    assign o_den_out        = r_den_out;
    assign o_compare_true   = r_cmp;
    assign o_div_zero_error = r_err;

endmodule

@@ rtl/core/rational_fraction_alu.sv @@
// Execution: each transaction uses the shared binary GCD unit (one step a
//   cycle) plus a divider pass, run twice for compares and a divide by
//   zero and three times for arithmetic.
// Queueing: a new transaction starts once the last result is taken; the queue
//   takes up to QUEUE_DEPTH further transactions while one executes.
// Reset: synchronous, active low; clears the queue and all control state.
// ----------------------------------------------------------------------------
// rational_fraction_alu
// Fraction add, subtract, multiply, divide and compare with GCD reduction.
// ----------------------------------------------------------------------------
module rational_fraction_alu #(
    parameter int QUEUE_DEPTH = rfa_pkg::RFA_QUEUE_DEPTH
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_valid,
    output logic               o_ready,
    input  logic [2:0]         i_opcode,
    input  logic signed [31:0] i_num_a,
    input  logic signed [31:0] i_den_a,
    input  logic signed [31:0] i_num_b,
    input  logic signed [31:0] i_den_b,
    output logic               o_valid,
    input  logic               i_ready,
    output logic signed [63:0] o_num_out,
    output logic [62:0]        o_den_out,
    output logic               o_compare_true,
    output logic               o_div_zero_error
);
    import rfa_pkg::*;

    t_front_ctl front_ctl;
    t_job       front_job;
    t_job       q_job;
    logic       q_full;
    logic       q_valid;
    logic       q_pop;

    rfa_front u_front (
        .i_valid  (i_valid),
        .o_ready  (o_ready),
        .i_opcode (i_opcode),
        .i_num_a  (i_num_a),
        .i_den_a  (i_den_a),
        .i_num_b  (i_num_b),
        .i_den_b  (i_den_b),
        .i_full   (q_full),
        .o_ctl    (front_ctl),
        .o_job    (front_job)
    );

    rfa_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (front_ctl.push),
        .i_job   (front_job),
        .o_full  (q_full),
        .i_pop   (q_pop),
        .o_valid (q_valid),
        .o_job   (q_job)
    );

    rfa_back u_back (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_q_valid        (q_valid),
        .i_job            (q_job),
        .o_pop            (q_pop),
        .o_valid          (o_valid),
        .i_ready          (i_ready),
        .o_num_out        (o_num_out),
        .o_den_out        (o_den_out),
        .o_compare_true   (o_compare_true),
        .o_div_zero_error (o_div_zero_error)
    );

endmodule

@@ rtl/core/rfa_checker.sv @@
// ----------------------------------------------------------------------------
// rfa_checker
// Port-level checks of the rational fraction ALU, bound to the top level.
// ----------------------------------------------------------------------------
module rfa_checker (
    input logic               i_clk,
    input logic               i_rst_n,
    input logic               o_valid,
    input logic               i_ready,
    input logic signed [63:0] o_num_out,
    input logic [62:0]        o_den_out,
    input logic               o_compare_true,
    input logic               o_div_zero_error
);

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && !i_ready |=> o_valid && $stable(o_num_out) && $stable(o_den_out))
        else $error("result dropped or changed while stalled");

    a_den_pos: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> o_den_out != '0)
        else $error("zero result denominator");

    a_cmp_form: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_compare_true |-> o_num_out == '0 && o_den_out == 63'd1
            && !o_div_zero_error)
        else $error("compare result not 0/1");

    a_err_form: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_div_zero_error |-> o_num_out == '0 && o_den_out == 63'd1)
        else $error("divide error result not 0/1");

endmodule

bind rational_fraction_alu rfa_checker u_rfa_checker (
    .i_clk            (i_clk),
    .i_rst_n          (i_rst_n),
    .o_valid          (o_valid),
    .i_ready          (i_ready),
    .o_num_out        (o_num_out),
    .o_den_out        (o_den_out),
    .o_compare_true   (o_compare_true),
    .o_div_zero_error (o_div_zero_error)
);
